// File: hdl/bitmap_next_set_bit_search_macros.svh
// Assertion macros used by the bitmap search controller.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef BITMAP_NEXT_SET_BIT_SEARCH_MACROS_SVH
`define BITMAP_NEXT_SET_BIT_SEARCH_MACROS_SVH

// Property must hold at every edge outside reset
`define BNSB_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Condition must never be seen outside reset
`define BNSB_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

// File: hdl/bnsb_pkg.sv
// Shared types, constants and the lowest-set-bit encoder for the bitmap search.
// No dependencies.
package bnsb_pkg;

    localparam int MAP_WORDS_DEF = 16;
    localparam int WORD_BITS_DEF = 64;

    localparam int IDX_W   = 4;    // word_index field
    localparam int VAL_W   = 64;   // word_value field
    localparam int START_W = 10;   // start_bit field
    localparam int LIM_W   = 11;   // bits_in_use and bit_index
    localparam int POS_W   = 12;   // internal bit positions, headroom for one word step

    localparam logic [LIM_W-1:0] BITS_IN_USE_RST = 11'd1024;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic take_item;   // latch start position
        logic wr_item;     // write one bitmap word
        logic clr_step;    // clear one word of the sweep after reset
        logic div_load;    // latch word index of the start position
        logic base_load;   // latch first word base and bit offset
        logic scan_adv;    // step to the next word
        logic res_hit;     // load result from the encoder
        logic res_miss;    // load result as not found
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_past;  // start at or past the limit, limit zero included
        logic hit;         // current word has a set bit
        logic last;        // next word starts at or past the limit
        logic clr_last;    // clear sweep is at its final word
    } ctrl_stat_t;

    // Position of the lowest set bit of a nonzero word
    function automatic logic [5:0] lowest_set(input logic [VAL_W-1:0] w);
        logic [VAL_W-1:0] v;
        logic [5:0]       n;
        v = w;
        n = '0;
        if (v[31:0] == '0) begin n[5] = 1'b1; v = v >> 32; end
        if (v[15:0] == '0) begin n[4] = 1'b1; v = v >> 16; end
        if (v[7:0]  == '0) begin n[3] = 1'b1; v = v >> 8;  end
        if (v[3:0]  == '0) begin n[2] = 1'b1; v = v >> 4;  end
        if (v[1:0]  == '0) begin n[1] = 1'b1; v = v >> 2;  end
        if (v[0]    == 1'b0) n[0] = 1'b1;
        return n;
    endfunction

endpackage

// File: hdl/bnsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bnsb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bnsb_ctrl.sv
// Controller of the bitmap search: clear sweep, item intake, scan sequencing,
// result register handshake. Depends on bnsb_pkg and the assertion macros.
`include "bitmap_next_set_bit_search_macros.svh"

module bnsb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  bnsb_pkg::ctrl_stat_t   stat,
    output bnsb_pkg::ctrl_cmd_t    cmd
);
    import bnsb_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_BASE  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_MISS  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_WRITE)
                    begin
                        cmd.wr_item = 1'b1;
                    end
                    else
                    begin
                        cmd.take_item = 1'b1;
                        state_next    = stat.start_past ? ST_MISS : ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_BASE;
            end
            ST_BASE:
            begin
                cmd.base_load = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // hold on the finishing word until the result register is free
                if (stat.hit)
                begin
                    if (out_free)
                    begin
                        cmd.res_hit = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else if (stat.last)
                begin
                    if (out_free)
                    begin
                        cmd.res_miss = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                end
            end
            ST_MISS:
            begin
                if (out_free)
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_hit || cmd.res_miss)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BNSB_NEVER(a_no_result_when_idle, in_ready && (cmd.res_hit || cmd.res_miss))
    `BNSB_ASSERT(a_one_scan_action, $onehot0({cmd.res_hit, cmd.res_miss, cmd.scan_adv}))
    `BNSB_ASSERT(a_result_slot_free, (cmd.res_hit || cmd.res_miss) |-> (!out_valid_reg || out_ready))
    `BNSB_ASSERT(a_clear_only_after_reset, (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))

endmodule

// File: hdl/bnsb_dp.sv
// Datapath of the bitmap search: configuration register, bitmap RAM, word index
// division, first-word mask, priority encoder, result register. Depends on bnsb_pkg, bnsb_ram.
module bnsb_dp #(
    parameter int MAP_WORDS = bnsb_pkg::MAP_WORDS_DEF,
    parameter int WORD_BITS = bnsb_pkg::WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [bnsb_pkg::LIM_W-1:0]     cfg_data,
    input  logic [bnsb_pkg::IDX_W-1:0]     word_index,
    input  logic [bnsb_pkg::VAL_W-1:0]     word_value,
    input  logic [bnsb_pkg::START_W-1:0]   start_bit,
    output logic [bnsb_pkg::LIM_W-1:0]     bit_index,
    output logic                           found,
    input  bnsb_pkg::ctrl_cmd_t            cmd,
    output bnsb_pkg::ctrl_stat_t           stat
);
    import bnsb_pkg::*;

    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int MAP_BITS  = MAP_WORDS * WORD_BITS;
    localparam int DIV_SH    = 20;
    // exact floor for positions below 1024 and word sizes up to 64
    localparam int DIV_RECIP = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

    logic [LIM_W-1:0]     cfg_reg;
    logic [START_W-1:0]   start_reg;
    logic [AW-1:0]        widx_reg;
    logic [POS_W-1:0]     base_reg;
    logic [OFF_W-1:0]     off_reg;
    logic                 first_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic [LIM_W-1:0]     bit_index_reg;
    logic                 found_reg;

    logic [LIM_W-1:0]     limit;
    logic [31:0]          div_prod;
    logic [31:0]          base_prod;
    logic [POS_W-1:0]     base_first;
    logic [POS_W-1:0]     off_full;
    logic [POS_W-1:0]     next_base;
    logic [POS_W-1:0]     cand;
    logic                 cand_lt;
    logic                 idx_ok;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] scan_word;

    assign limit = (32'(cfg_reg) > MAP_BITS) ? LIM_W'(MAP_BITS) : cfg_reg;

    assign idx_ok    = 32'(word_index) < MAP_WORDS;
    assign ram_we    = cmd.clr_step || (cmd.wr_item && idx_ok);
    assign ram_waddr = cmd.clr_step ? clr_addr_reg : AW'(word_index);
    assign ram_wdata = cmd.clr_step ? '0 : word_value[WORD_BITS-1:0];
    // prefetch the next word while stepping so one word is checked per cycle
    assign ram_raddr = cmd.scan_adv ? AW'(widx_reg + 1'b1) : widx_reg;

    bnsb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_prod   = 32'(start_reg) * 32'(DIV_RECIP);
    assign base_prod  = 32'(widx_reg) * 32'(WORD_BITS);
    assign base_first = base_prod[POS_W-1:0];
    assign off_full   = POS_W'(start_reg) - base_first;

    assign word_mask = first_reg ? ({WORD_BITS{1'b1}} << off_reg) : '1;
    assign scan_word = ram_rdata & word_mask;
    assign cand      = base_reg + POS_W'(lowest_set(VAL_W'(scan_word)));
    assign cand_lt   = cand < POS_W'(limit);
    assign next_base = base_reg + POS_W'(WORD_BITS);

    assign stat.start_past = LIM_W'(start_bit) >= limit;
    assign stat.hit        = |scan_word;
    assign stat.last       = next_base >= POS_W'(limit);
    assign stat.clr_last   = 32'(clr_addr_reg) == (MAP_WORDS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= BITS_IN_USE_RST;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= AW'(clr_addr_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            start_reg <= start_bit;
        end
        if (cmd.div_load)
        begin
            widx_reg <= div_prod[DIV_SH +: AW];
        end
        else if (cmd.scan_adv)
        begin
            widx_reg <= AW'(widx_reg + 1'b1);
        end
        if (cmd.base_load)
        begin
            base_reg  <= base_first;
            off_reg   <= off_full[OFF_W-1:0];
            first_reg <= 1'b1;
        end
        else if (cmd.scan_adv)
        begin
            base_reg  <= next_base;
            first_reg <= 1'b0;
        end
        if (cmd.res_hit)
        begin
            bit_index_reg <= cand_lt ? cand[LIM_W-1:0] : limit;
            found_reg     <= cand_lt;
        end
        else if (cmd.res_miss)
        begin
            bit_index_reg <= limit;
            found_reg     <= 1'b0;
        end
    end

    assign bit_index = bit_index_reg;
    assign found     = found_reg;

endmodule

// File: hdl/bitmap_next_set_bit_search.sv
// Bitmap next-set-bit search: top level joining controller and datapath.
// Depends on bnsb_pkg, bnsb_ctrl, bnsb_dp (and bnsb_ram below it).
//
// Input channel (in_valid/in_ready): mode selects a word write or a search.
// A write beat stores word_value into word word_index and gives no result;
// indexes past the map are dropped. A search beat gives start_bit.
// Output channel (out_valid/out_ready): one beat per search with bit_index,
// the lowest set bit at or above start_bit and below the limit, and found.
// With no such bit, bit_index is the limit and found is low. The limit is
// bits_in_use, capped at MAP_WORDS * WORD_BITS.
// Config channel (cfg_valid/cfg_ready): writes bits_in_use; always ready.
// Search: the start is latched, then its word index is divided out, then the
// first word's base and bit offset are loaded while that word is read from the
// bitmap RAM. The scan checks one word per cycle, prefetching the next, until a
// hit or the last word, and loads the result register once it is free; a start
// at or past the limit goes straight to a not-found result. A new item is taken
// the cycle after a search loads its result; writes go back to back, one per cycle.
// Reset: the clear sweep writes zero to every word of the bitmap RAM, with in_ready low.
// A stalled receiver holds the result register; a finishing search then waits.
module bitmap_next_set_bit_search #(
    parameter int MAP_WORDS = bnsb_pkg::MAP_WORDS_DEF,
    parameter int WORD_BITS = bnsb_pkg::WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [0:0]                     mode,
    input  logic [bnsb_pkg::IDX_W-1:0]     word_index,
    input  logic [bnsb_pkg::VAL_W-1:0]     word_value,
    input  logic [bnsb_pkg::START_W-1:0]   start_bit,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bnsb_pkg::LIM_W-1:0]     bit_index,
    output logic                           found,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bnsb_pkg::LIM_W-1:0]     cfg_data
);
    import bnsb_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    bnsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode[0]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bnsb_dp #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .word_index (word_index),
        .word_value (word_value),
        .start_bit  (start_bit),
        .bit_index  (bit_index),
        .found      (found),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

// File: tb/sv/bitmap_next_set_bit_search_tb.sv
// Testbench for bitmap_next_set_bit_search: directed table, then random word writes
// and searches checked against an in-bench next-set-bit predictor.
// Depends on bnsb_pkg and the bitmap_next_set_bit_search RTL.
module bitmap_next_set_bit_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bnsb_pkg::*;

    localparam int N_WORDS       = 16;
    localparam int N_BITS        = 64;
    localparam int MAP_SIZE      = N_WORDS * N_BITS;
    localparam int SETTLE_CYCLES = N_WORDS + 8;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic [LIM_W-1:0] bit_index;
        logic             found;
    } search_result_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SEARCH, ROW_LIMIT} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [IDX_W-1:0]   word;
        logic [VAL_W-1:0]   value;
        logic [START_W-1:0] start;
        logic [LIM_W-1:0]   limit;
        logic               pinned;
        logic [LIM_W-1:0]   want_index;
        logic               want_found;
    } dir_row_t;

    localparam int N_ROWS = 28;
    localparam logic [VAL_W-1:0] ONES = {VAL_W{1'b1}};

    // pinned rows carry an answer that follows directly from the bitmap contents
    localparam dir_row_t DIR_ROWS [0:N_ROWS-1] = '{
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd0,    11'd0,    1'b1, 11'd1024, 1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd1023, 11'd0,    1'b1, 11'd1024, 1'b0},
        '{ROW_WRITE,  4'd0,  64'd1,                 10'd0,    11'd0,    1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd0,    11'd0,    1'b1, 11'd0,    1'b1},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd1,    11'd0,    1'b1, 11'd1024, 1'b0},
        '{ROW_WRITE,  4'd15, 64'h8000_0000_0000_0000, 10'd0,  11'd0,    1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd1,    11'd0,    1'b1, 11'd1023, 1'b1},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd1023, 11'd0,    1'b1, 11'd1023, 1'b1},
        '{ROW_WRITE,  4'd7,  ONES,                  10'd0,    11'd0,    1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd500,  11'd0,    1'b1, 11'd500,  1'b1},
        '{ROW_WRITE,  4'd3,  64'h0123_4567_89ab_cdef, 10'd0,  11'd0,    1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd200,  11'd0,    1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd63,   11'd0,    1'b0, 11'd0,    1'b0},
        '{ROW_LIMIT,  4'd0,  64'd0,                 10'd0,    11'd0,    1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd0,    11'd0,    1'b1, 11'd0,    1'b0},
        '{ROW_LIMIT,  4'd0,  64'd0,                 10'd0,    11'd1,    1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd0,    11'd0,    1'b1, 11'd0,    1'b1},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd1,    11'd0,    1'b1, 11'd1,    1'b0},
        '{ROW_LIMIT,  4'd0,  64'd0,                 10'd0,    11'd2047, 1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd1000, 11'd0,    1'b1, 11'd1023, 1'b1},
        '{ROW_LIMIT,  4'd0,  64'd0,                 10'd0,    11'd1023, 1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd512,  11'd0,    1'b1, 11'd1023, 1'b0},
        '{ROW_LIMIT,  4'd0,  64'd0,                 10'd0,    11'd500,  1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd499,  11'd0,    1'b1, 11'd499,  1'b1},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd500,  11'd0,    1'b1, 11'd500,  1'b0},
        '{ROW_WRITE,  4'd7,  64'd0,                 10'd0,    11'd0,    1'b0, 11'd0,    1'b0},
        '{ROW_SEARCH, 4'd0,  64'd0,                 10'd449,  11'd0,    1'b0, 11'd0,    1'b0},
        '{ROW_LIMIT,  4'd0,  64'd0,                 10'd0,    11'd1024, 1'b0, 11'd0,    1'b0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [0:0]          mode = MODE_WRITE;
    logic [IDX_W-1:0]    word_index = '0;
    logic [VAL_W-1:0]    word_value = '0;
    logic [START_W-1:0]  start_bit = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [LIM_W-1:0]    bit_index;
    logic                found;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LIM_W-1:0]    cfg_data = '0;

    // answer override for pinned table rows, moves with the input beat
    logic                pin_valid = 1'b0;
    search_result_t      pin_result = '0;

    logic [VAL_W-1:0]    model_words [0:N_WORDS-1];
    logic [LIM_W-1:0]    model_bits_in_use;
    search_result_t      awaited_results [$];
    int                  mismatch_count = 0;
    bit                  no_idle = 1'b0;
    int                  ready_hold = 0;

    bitmap_next_set_bit_search u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .word_index (word_index),
        .word_value (word_value),
        .start_bit  (start_bit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bit_index  (bit_index),
        .found      (found),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Lowest set bit at or above start and below the capped limit
    function automatic search_result_t next_set_bit(input logic [START_W-1:0] start);
        search_result_t   r;
        int               limit;
        int               base;
        int               widx;
        int               res;
        int               lsb;
        logic [VAL_W-1:0] w;
        limit = (model_bits_in_use > MAP_SIZE) ? MAP_SIZE : int'(model_bits_in_use);
        res = limit;
        if (limit != 0 && int'(start) < limit)
        begin
            widx = start / N_BITS;
            base = widx * N_BITS;
            w = model_words[widx] & (ONES << (start % N_BITS));
            while (w == '0)
            begin
                base += N_BITS;
                if (base >= limit)
                    break;
                widx = base / N_BITS;
                w = (widx < N_WORDS) ? model_words[widx] : '0;
            end
            if (w != '0)
            begin
                lsb = 0;
                for (int b = N_BITS - 1; b >= 0; b--)
                    if (w[b])
                        lsb = b;
                res = (base + lsb < limit) ? base + lsb : limit;
            end
        end
        r.bit_index = res[LIM_W-1:0];
        r.found = (res < limit);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly sparse words so that searches have to walk across several words
    function automatic logic [VAL_W-1:0] pick_word_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = '0;
            3, 4, 5: v = 64'd1 << $urandom_range(0, 63);
            6:       v = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
            7:       v = ONES;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 99)) inside
                [0:69]:  out_ready <= 1'b1;
                [70:94]:
                begin
                    out_ready <= no_idle;
                    ready_hold = no_idle ? 0 : $urandom_range(0, 2);
                end
                default:
                begin
                    out_ready <= no_idle;
                    ready_hold = no_idle ? 0 : $urandom_range(5, 30);
                end
            endcase
        end
    end

    // Track accepted beats, predict searches, check results in order
    always @(posedge clk)
    begin
        search_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                model_bits_in_use = cfg_data;
            if (in_valid && in_ready)
            begin
                if (mode == MODE_WRITE)
                    model_words[word_index] = word_value;
                else
                begin
                    want = next_set_bit(start_bit);
                    if (pin_valid)
                        want = pin_result;
                    awaited_results.push_back(want);
                end
            end
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with none awaited: bit_index %0d found %0b",
                           bit_index, found);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (bit_index !== want.bit_index)
                    begin
                        $error("bit_index: expected %0d, actual %0d", want.bit_index, bit_index);
                        mismatch_count++;
                    end
                    if (found !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b", want.found, found);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic send_item(input logic m, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic [START_W-1:0] start,
                             input logic pinned, input search_result_t pin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        word_index <= idx;
        word_value <= val;
        start_bit  <= start;
        pin_valid  <= pinned;
        pin_result <= pin;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold the sender until every search has answered and the block has gone quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        dir_row_t       row;
        search_result_t pin;
        logic           m;
        logic [LIM_W-1:0] phase_limit;
        int             lim_cap;
        int             s;

        for (int i = 0; i < N_WORDS; i++)
            model_words[i] = '0;
        model_bits_in_use = BITS_IN_USE_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            row = DIR_ROWS[i];
            pin.bit_index = row.want_index;
            pin.found = row.want_found;
            case (row.kind)
                ROW_LIMIT:  write_limit(row.limit);
                ROW_WRITE:  send_item(MODE_WRITE, row.word, row.value, row.start, 1'b0, pin);
                default:    send_item(MODE_SEARCH, row.word, row.value, row.start,
                                      row.pinned, pin);
            endcase
        end

        pin = '0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:       phase_limit = 11'd1024;
                1:       phase_limit = 11'd0;
                2:       phase_limit = 11'd2047;
                3:       phase_limit = 11'd1;
                4:       phase_limit = LIM_W'($urandom_range(2, 1023));
                5:       phase_limit = 11'd64;
                6:       phase_limit = LIM_W'($urandom_range(0, 2047));
                default: phase_limit = 11'd1023;
            endcase
            write_limit(phase_limit);
            no_idle = (p == 2 || p == 5);
            lim_cap = (phase_limit > MAP_SIZE) ? MAP_SIZE : int'(phase_limit);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 && p % 2 == 1)
                    wait_idle();
                m = ($urandom_range(0, 99) < 40) ? MODE_WRITE : MODE_SEARCH;
                // bias some starts to sit right around the limit
                if ($urandom_range(0, 3) == 0)
                begin
                    s = lim_cap + $urandom_range(0, 3) - 2;
                    s = (s < 0) ? 0 : (s > MAP_SIZE - 1) ? MAP_SIZE - 1 : s;
                end
                else
                    s = $urandom_range(0, MAP_SIZE - 1);
                send_item(m, IDX_W'($urandom_range(0, N_WORDS - 1)), pick_word_value(),
                          s[START_W-1:0], 1'b0, pin);
            end
        end
        no_idle = 1'b0;

        wait_idle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bnsb_pkg.sv
hdl/bnsb_ram.sv
hdl/bnsb_ctrl.sv
hdl/bnsb_dp.sv
hdl/bitmap_next_set_bit_search.sv
tb/sv/bitmap_next_set_bit_search_tb.sv
